// ===== hdl/dtnms_pkg.sv =====
// Shared types, constants and state codes for the detection top-K NMS unit.
package dtnms_pkg;

  localparam int TOP_K_DEF   = 32;
  localparam int MAX_RESULTS = 32;

  localparam logic [8:0] IOU_THR_RST  = 9'd154;
  localparam logic [7:0] MIN_SIZE_RST = 8'd2;
  localparam logic [5:0] KEEP_CNT_RST = 6'd32;

  // floor(p/255) = (p * CONF_RECIP) >> 24 for p < 2^16
  localparam logic [16:0] CONF_RECIP = 17'd65794;
  // floor(x/255) = (x * EDGE_RECIP) >> 30 for x < 2^22
  localparam logic [22:0] EDGE_RECIP = 23'd4210753;

  typedef enum logic [1:0] {
    CFG_IOU_THR  = 2'd0,
    CFG_MIN_SIZE = 2'd1,
    CFG_KEEP_CNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_INS,
    ST_SUP_INIT,
    ST_PIV,
    ST_CMP_ROT,
    ST_CMP1,
    ST_CMP2,
    ST_CMP3,
    ST_PIV_NEXT,
    ST_SCAN,
    ST_EM_LOAD,
    ST_EM_OUT,
    ST_NF,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  conf;
    logic        tag;
    logic [15:0] area;
    logic        sup;
  } entry_t;

  typedef struct packed {
    logic cap_in;
    logic calc_conf;
    logic insert;
    logic sup_init;
    logic rotate;
    logic inc_i;
    logic load_a;
    logic clr_k;
    logic inc_k;
    logic s1;
    logic s2;
    logic mark;
    logic scan_init;
    logic scan_upd;
    logic emit_load;
    logic emit_out;
    logic emit_nf;
    logic clr_total;
  } cmd_t;

  typedef struct packed {
    logic final_item;
    logic i_eq_n;
    logic k_eq_n;
    logic head_sup;
    logic emit_ok;
    logic has_surv;
  } sts_t;

endpackage

// ===== hdl/detection_topk_nms_unit.sv =====
// Top level of the detection top-K selection and NMS unit.
//
//  channel  ports                      transfer
//  input    start/busy, in_*           start high while busy low
//  result   out_strobe, out_*          one cycle per result, no backpressure
//  config   cfg_we, cfg_index, cfg_data  cfg_we high
//
// No new item is accepted while busy: busy stays high after the transfer through
// score scaling and insert. On a final item the list of n boxes is swept by rotation:
// suppression through the shared IoU compare unit, then a scan and the emission.
// Reset (rst_n low, synchronous) empties the list and loads register defaults.
module detection_topk_nms_unit import dtnms_pkg::*; #(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_center_x,
  input  logic [7:0]  in_center_y,
  input  logic [7:0]  in_box_w,
  input  logic [7:0]  in_box_h,
  input  logic [7:0]  in_objectness,
  input  logic [7:0]  in_violated_score,
  input  logic [7:0]  in_fine_score,
  input  logic        in_final_item,
  output logic        out_strobe,
  output logic        out_found,
  output logic [13:0] out_left_q4,
  output logic [13:0] out_top_q4,
  output logic [13:0] out_width_q4,
  output logic [13:0] out_height_q4,
  output logic        out_tag,
  output logic [7:0]  out_confidence,
  output logic        out_largest,
  output logic        out_end_of_run,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;

  dtnms_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dtnms_dp #(.TOP_K(TOP_K)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_box_w          (in_box_w),
    .in_box_h          (in_box_h),
    .in_objectness     (in_objectness),
    .in_violated_score (in_violated_score),
    .in_fine_score     (in_fine_score),
    .in_final_item     (in_final_item),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_left_q4       (out_left_q4),
    .out_top_q4        (out_top_q4),
    .out_width_q4      (out_width_q4),
    .out_height_q4     (out_height_q4),
    .out_tag           (out_tag),
    .out_confidence    (out_confidence),
    .out_largest       (out_largest),
    .out_end_of_run    (out_end_of_run)
  );

endmodule

// ===== hdl/dtnms_ctrl.sv =====
// Sequencer for item intake, suppression passes and result emission.
module dtnms_ctrl import dtnms_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.cap_in = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.calc_conf = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_INS;
      end
      ST_INS: begin
        if (sts.final_item) begin
          cmd.sup_init = 1'b1;
          state_nxt    = ST_SUP_INIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUP_INIT: state_nxt = ST_PIV;
      ST_PIV: begin
        if (sts.i_eq_n) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else if (sts.head_sup) begin
          cmd.rotate = 1'b1;
          cmd.inc_i  = 1'b1;
        end else begin
          cmd.load_a = 1'b1;
          cmd.clr_k  = 1'b1;
          state_nxt  = ST_CMP_ROT;
        end
      end
      ST_CMP_ROT: begin
        cmd.rotate = 1'b1;
        cmd.inc_k  = 1'b1;
        state_nxt  = ST_CMP1;
      end
      ST_CMP1: begin
        cmd.s1    = 1'b1;
        state_nxt = ST_CMP2;
      end
      ST_CMP2: begin
        cmd.s2    = 1'b1;
        state_nxt = ST_CMP3;
      end
      ST_CMP3: begin
        cmd.mark  = 1'b1;
        state_nxt = sts.k_eq_n ? ST_PIV_NEXT : ST_CMP_ROT;
      end
      ST_PIV_NEXT: begin
        cmd.rotate = 1'b1;
        cmd.inc_i  = 1'b1;
        state_nxt  = ST_PIV;
      end
      ST_SCAN: begin
        if (sts.k_eq_n) begin
          cmd.clr_k = 1'b1;
          state_nxt = ST_EM_LOAD;
        end else begin
          cmd.scan_upd = 1'b1;
          cmd.rotate   = 1'b1;
          cmd.inc_k    = 1'b1;
        end
      end
      ST_EM_LOAD: begin
        if (sts.k_eq_n) begin
          state_nxt = sts.has_surv ? ST_FIN : ST_NF;
        end else if (sts.emit_ok) begin
          cmd.emit_load = 1'b1;
          state_nxt     = ST_EM_OUT;
        end else begin
          cmd.rotate = 1'b1;
          cmd.inc_k  = 1'b1;
        end
      end
      ST_EM_OUT: begin
        cmd.emit_out = 1'b1;
        cmd.rotate   = 1'b1;
        cmd.inc_k    = 1'b1;
        state_nxt    = ST_EM_LOAD;
      end
      ST_NF: begin
        cmd.emit_nf = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_FIN: begin
        cmd.clr_total = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hdl/dtnms_dp.sv =====
// Datapath: config registers, sorted list with shift insert and rotation, IoU and output math.
module dtnms_dp import dtnms_pkg::*; #(
  parameter int TOP_K = TOP_K_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic [7:0]  in_center_x,
  input  logic [7:0]  in_center_y,
  input  logic [7:0]  in_box_w,
  input  logic [7:0]  in_box_h,
  input  logic [7:0]  in_objectness,
  input  logic [7:0]  in_violated_score,
  input  logic [7:0]  in_fine_score,
  input  logic        in_final_item,
  output logic        out_strobe,
  output logic        out_found,
  output logic [13:0] out_left_q4,
  output logic [13:0] out_top_q4,
  output logic [13:0] out_width_q4,
  output logic [13:0] out_height_q4,
  output logic        out_tag,
  output logic [7:0]  out_confidence,
  output logic        out_largest,
  output logic        out_end_of_run
);

  localparam int CW = $clog2(TOP_K + 1);
  localparam int IW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [6:0] TOPK7 = 7'(TOP_K);
  localparam logic [5:0] MAXR  = 6'(MAX_RESULTS);

  logic [8:0] iou_thr_r;
  logic [7:0] min_size_r;
  logic [5:0] keep_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iou_thr_r  <= IOU_THR_RST;
      min_size_r <= MIN_SIZE_RST;
      keep_cnt_r <= KEEP_CNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IOU_THR:  iou_thr_r  <= cfg_data;
        CFG_MIN_SIZE: min_size_r <= cfg_data[7:0];
        CFG_KEEP_CNT: keep_cnt_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  logic [6:0]    lim7;
  logic [CW-1:0] lim;
  always_comb begin
    if (keep_cnt_r == 6'd0) lim7 = 7'd1;
    else if ({1'b0, keep_cnt_r} > TOPK7) lim7 = TOPK7;
    else lim7 = {1'b0, keep_cnt_r};
  end
  assign lim = lim7[CW-1:0];

  // intake
  logic [7:0]  cx_r, cy_r, w_r, h_r;
  logic [15:0] p0_r, p1_r, area_r;
  logic        final_r;
  logic [7:0]  nconf_r;
  logic        ntag_r, nok_r;
  logic [32:0] q0_full, q1_full;
  logic [7:0]  c0, c1;

  assign q0_full = {17'd0, p0_r} * {16'd0, CONF_RECIP};
  assign q1_full = {17'd0, p1_r} * {16'd0, CONF_RECIP};
  assign c0 = q0_full[31:24];
  assign c1 = q1_full[31:24];

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      w_r     <= in_box_w;
      h_r     <= in_box_h;
      p0_r    <= in_violated_score * in_objectness;
      p1_r    <= in_fine_score * in_objectness;
      area_r  <= in_box_w * in_box_h;
      final_r <= in_final_item;
    end
    if (cmd.calc_conf) begin
      ntag_r  <= (c0 > c1);
      nconf_r <= (c0 > c1) ? c0 : c1;
      nok_r   <= (w_r >= min_size_r) && (h_r >= min_size_r);
    end
  end

  // list
  entry_t        ent_r [TOP_K];
  logic [CW-1:0] total_r, n_r, i_r, k_r;
  logic [CW-1:0] total_c, lim_m1;
  logic [TOP_K-1:0] ge;
  logic          ins_ok;
  entry_t        nent;

  assign total_c = (total_r > lim) ? lim : total_r;
  assign lim_m1  = lim - CW'(1);

  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      ge[k] = (CW'(k) < total_c) && (ent_r[k].conf >= nconf_r);
    end
  end
  assign ins_ok = !ge[lim_m1[IW-1:0]];

  always_comb begin
    nent.cx   = cx_r;
    nent.cy   = cy_r;
    nent.w    = w_r;
    nent.h    = h_r;
    nent.conf = nconf_r;
    nent.tag  = ntag_r;
    nent.area = area_r;
    nent.sup  = 1'b0;
  end

  logic [CW:0] ik_sum;
  logic        mark_dec;
  assign ik_sum = {1'b0, i_r} + {1'b0, k_r};

  always_ff @(posedge clk) begin
    if (cmd.insert && nok_r && ins_ok) begin
      for (int k = 0; k < TOP_K; k++) begin
        if (k == 0) begin
          if (!ge[0]) ent_r[0] <= nent;
        end else if (ge[k-1] && !ge[k]) begin
          ent_r[k] <= nent;
        end else if (!ge[k-1]) begin
          ent_r[k] <= ent_r[k-1];
        end
      end
    end else if (cmd.sup_init) begin
      for (int k = 0; k < TOP_K; k++) ent_r[k].sup <= 1'b0;
    end else if (cmd.rotate) begin
      for (int k = 0; k < TOP_K; k++) begin
        if (CW'(k) == n_r - CW'(1)) ent_r[k] <= ent_r[0];
        else if (k < TOP_K - 1) ent_r[k] <= ent_r[(k + 1) % TOP_K];
      end
    end else if (cmd.mark && mark_dec && (ik_sum < {1'b0, n_r})) begin
      ent_r[0].sup <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.insert && nok_r) begin
      if (ins_ok) total_r <= (total_c < lim) ? total_c + CW'(1) : lim;
      else total_r <= total_c;
    end else if (cmd.sup_init) begin
      total_r <= total_c;
    end else if (cmd.clr_total) begin
      total_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sup_init) n_r <= total_c;
    if (cmd.sup_init) i_r <= '0;
    else if (cmd.inc_i) i_r <= i_r + CW'(1);
    if (cmd.clr_k || cmd.scan_init) k_r <= '0;
    else if (cmd.inc_k) k_r <= k_r + CW'(1);
  end

  // IoU
  entry_t      a_r;
  logic [9:0]  ix_r, iy_r;
  logic [18:0] sum_r;
  logic [19:0] inter_r;
  logic [27:0] tsum_r;
  logic [29:0] lhs;

  function automatic logic [8:0] lo_edge(input logic [7:0] c, input logic [7:0] s);
    logic [8:0] c2;
    c2 = {c, 1'b0};
    return (c2 > {1'b0, s}) ? c2 - {1'b0, s} : 9'd0;
  endfunction

  function automatic logic [9:0] ovl(input logic [8:0] a0, input logic [7:0] as,
                                     input logic [8:0] b0, input logic [7:0] bs);
    logic [9:0] lo, ea, eb, hi;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    ea = {1'b0, a0} + {1'b0, as, 1'b0};
    eb = {1'b0, b0} + {1'b0, bs, 1'b0};
    hi = (ea < eb) ? ea : eb;
    return (hi > lo) ? hi - lo : 10'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_a) a_r <= ent_r[0];
    if (cmd.s1) begin
      ix_r  <= ovl(lo_edge(a_r.cx, a_r.w), a_r.w, lo_edge(ent_r[0].cx, ent_r[0].w), ent_r[0].w);
      iy_r  <= ovl(lo_edge(a_r.cy, a_r.h), a_r.h, lo_edge(ent_r[0].cy, ent_r[0].h), ent_r[0].h);
      sum_r <= {({1'b0, a_r.area} + {1'b0, ent_r[0].area}), 2'b00};
    end
    if (cmd.s2) begin
      inter_r <= ix_r * iy_r;
      tsum_r  <= iou_thr_r * sum_r;
    end
  end

  assign lhs      = ({1'b0, iou_thr_r} + 10'd256) * inter_r;
  assign mark_dec = lhs > {2'b00, tsum_r};

  // scan and emission
  logic [5:0]  scnt_r, ecnt_r, bestk_r;
  logic [15:0] best_r;
  logic        surv_ok;

  assign surv_ok = !ent_r[0].sup && (scnt_r < MAXR);

  logic [8:0] st_left_r, st_top_r;
  logic [7:0] st_w_r, st_h_r, st_conf_r;
  logic       st_tag_r, st_lg_r, st_eor_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scnt_r  <= '0;
      ecnt_r  <= '0;
      best_r  <= '0;
      bestk_r <= '0;
    end else begin
      if (cmd.scan_upd && surv_ok) begin
        if (scnt_r == 6'd0 || ent_r[0].area > best_r) begin
          best_r  <= ent_r[0].area;
          bestk_r <= scnt_r;
        end
        scnt_r <= scnt_r + 6'd1;
      end
      if (cmd.emit_out) ecnt_r <= ecnt_r + 6'd1;
    end
    if (cmd.emit_load) begin
      st_left_r <= lo_edge(ent_r[0].cx, ent_r[0].w);
      st_top_r  <= lo_edge(ent_r[0].cy, ent_r[0].h);
      st_w_r    <= ent_r[0].w;
      st_h_r    <= ent_r[0].h;
      st_conf_r <= ent_r[0].conf;
      st_tag_r  <= ent_r[0].tag;
      st_lg_r   <= (ecnt_r == bestk_r);
      st_eor_r  <= (ecnt_r == scnt_r - 6'd1);
    end
  end

  logic [20:0] xl, xt, xw, xh;
  logic [43:0] ql, qt, qw, qh;
  assign xl = {st_left_r, 12'd0} + 21'd127;
  assign xt = {st_top_r, 12'd0} + 21'd127;
  assign xw = {st_w_r, 13'd0} + 21'd127;
  assign xh = {st_h_r, 13'd0} + 21'd127;
  assign ql = xl * EDGE_RECIP;
  assign qt = xt * EDGE_RECIP;
  assign qw = xw * EDGE_RECIP;
  assign qh = xh * EDGE_RECIP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit_out || cmd.emit_nf;
    end
    if (cmd.emit_out) begin
      out_found      <= 1'b1;
      out_left_q4    <= ql[43:30];
      out_top_q4     <= qt[43:30];
      out_width_q4   <= qw[43:30];
      out_height_q4  <= qh[43:30];
      out_tag        <= st_tag_r;
      out_confidence <= st_conf_r;
      out_largest    <= st_lg_r;
      out_end_of_run <= st_eor_r;
    end else if (cmd.emit_nf) begin
      out_found      <= 1'b0;
      out_left_q4    <= '0;
      out_top_q4     <= '0;
      out_width_q4   <= '0;
      out_height_q4  <= '0;
      out_tag        <= 1'b0;
      out_confidence <= '0;
      out_largest    <= 1'b0;
      out_end_of_run <= 1'b1;
    end
  end

  assign sts.final_item = final_r;
  assign sts.i_eq_n     = (i_r == n_r);
  assign sts.k_eq_n     = (k_r == n_r);
  assign sts.head_sup   = ent_r[0].sup;
  assign sts.emit_ok    = !ent_r[0].sup && (ecnt_r < scnt_r);
  assign sts.has_surv   = (scnt_r != 6'd0);

endmodule

// ===== bench/detection_topk_nms_unit_test.sv =====
// Testbench for the detection top-K NMS unit: directed table and random frames.
module detection_topk_nms_unit_test import dtnms_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] cx, cy, w, h, obj, vs, fs;
    logic       fin;
  } cand_t;

  typedef struct {
    logic        found;
    logic [13:0] left, top, wid, hgt;
    logic        tag;
    logic [7:0]  conf;
    logic        largest, eor;
  } det_t;

  typedef struct {
    logic [7:0] cx, cy, w, h, conf;
    logic       tag;
  } box_t;

  typedef struct {
    cand_t c;
    logic  chk;
    det_t  d;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_center_x = '0, in_center_y = '0, in_box_w = '0, in_box_h = '0;
  logic [7:0] in_objectness = '0, in_violated_score = '0, in_fine_score = '0;
  logic in_final_item = 1'b0;
  logic out_strobe, out_found, out_tag, out_largest, out_end_of_run;
  logic [13:0] out_left_q4, out_top_q4, out_width_q4, out_height_q4;
  logic [7:0] out_confidence;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_IOU_THR;
  logic [8:0] cfg_data = '0;

  detection_topk_nms_unit uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  box_t list_q[$];
  det_t det_q[$];
  int unsigned thr_r = 154, minsz_r = 2, keep_r = 32;
  int errors = 0;
  int idle_cycles = 0;
  localparam int WATCHDOG = 40000;

  function automatic int unsigned keep_eff();
    if (keep_r < 1) return 1;
    if (keep_r > 32) return 32;
    return keep_r;
  endfunction

  function automatic longint unsigned edge_lo(int unsigned c, int unsigned s);
    return (2 * c > s) ? 2 * c - s : 0;
  endfunction

  function automatic longint unsigned ovl(longint unsigned a0, longint unsigned al,
                                          longint unsigned b0, longint unsigned bl);
    longint unsigned lo, hi;
    lo = a0 > b0 ? a0 : b0;
    hi = (a0 + al) < (b0 + bl) ? a0 + al : b0 + bl;
    return hi > lo ? hi - lo : 0;
  endfunction

  function automatic bit overlaps_too_much(box_t a, box_t b);
    longint unsigned ix, iy, inter, uni;
    ix = ovl(edge_lo(a.cx, a.w), 2 * a.w, edge_lo(b.cx, b.w), 2 * b.w);
    iy = ovl(edge_lo(a.cy, a.h), 2 * a.h, edge_lo(b.cy, b.h), 2 * b.h);
    inter = ix * iy;
    uni = 4 * a.w * a.h + 4 * b.w * b.h - inter;
    return 256 * inter > thr_r * uni;
  endfunction

  task automatic predict_detections(cand_t c);
    box_t nb, a;
    int unsigned c0, c1, lim, pos, n, cnt, best_area, best_k, area;
    bit sup[32];
    det_t d;
    det_t frame[$];
    c0 = (c.vs * c.obj) / 255;
    c1 = (c.fs * c.obj) / 255;
    nb = '{c.cx, c.cy, c.w, c.h, 8'((c0 > c1) ? c0 : c1), c0 > c1};
    if (c.w >= minsz_r && c.h >= minsz_r) begin
      lim = keep_eff();
      while (list_q.size() > lim) void'(list_q.pop_back());
      pos = 0;
      while (pos < list_q.size() && list_q[pos].conf >= nb.conf) pos++;
      if (pos < lim) begin
        list_q.insert(pos, nb);
        if (list_q.size() > lim) void'(list_q.pop_back());
      end
    end
    if (!c.fin) return;
    while (list_q.size() > keep_eff()) void'(list_q.pop_back());
    n = list_q.size();
    foreach (sup[i]) sup[i] = 0;
    cnt = 0; best_area = 0; best_k = 0;
    for (int i = 0; i < n && cnt < 32; i++) begin
      if (sup[i]) continue;
      a = list_q[i];
      for (int j = i + 1; j < n; j++)
        if (overlaps_too_much(a, list_q[j])) sup[j] = 1;
      d.found = 1;
      d.left = 14'((edge_lo(a.cx, a.w) * 8192 + 255) / 510);
      d.top = 14'((edge_lo(a.cy, a.h) * 8192 + 255) / 510);
      d.wid = 14'((a.w * 16384 + 255) / 510);
      d.hgt = 14'((a.h * 16384 + 255) / 510);
      d.tag = a.tag;
      d.conf = a.conf;
      d.largest = 0;
      d.eor = 0;
      area = a.w * a.h;
      if (cnt == 0 || area > best_area) begin
        best_area = area;
        best_k = cnt;
      end
      frame.insert(frame.size(), d);
      cnt++;
    end
    if (cnt == 0) begin
      d = '{0, 0, 0, 0, 0, 0, 0, 0, 1};
      frame.insert(frame.size(), d);
    end else begin
      frame[best_k].largest = 1;
      frame[cnt - 1].eor = 1;
    end
    foreach (frame[i]) det_q.insert(det_q.size(), frame[i]);
    list_q.delete();
  endtask

  always @(posedge clk) begin
    det_t e;
    if (rst_n && out_strobe) begin
      if (det_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = det_q.pop_front();
        if (out_found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_found); errors++;
        end
        if (out_left_q4 !== e.left) begin
          $error("left_q4 exp %0d got %0d", e.left, out_left_q4); errors++;
        end
        if (out_top_q4 !== e.top) begin
          $error("top_q4 exp %0d got %0d", e.top, out_top_q4); errors++;
        end
        if (out_width_q4 !== e.wid) begin
          $error("width_q4 exp %0d got %0d", e.wid, out_width_q4); errors++;
        end
        if (out_height_q4 !== e.hgt) begin
          $error("height_q4 exp %0d got %0d", e.hgt, out_height_q4); errors++;
        end
        if (out_tag !== e.tag) begin
          $error("tag exp %0d got %0d", e.tag, out_tag); errors++;
        end
        if (out_confidence !== e.conf) begin
          $error("confidence exp %0d got %0d", e.conf, out_confidence); errors++;
        end
        if (out_largest !== e.largest) begin
          $error("largest exp %0d got %0d", e.largest, out_largest); errors++;
        end
        if (out_end_of_run !== e.eor) begin
          $error("end_of_run exp %0d got %0d", e.eor, out_end_of_run); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // start stays high across back-to-back calls; this task drops it only when a gap is drawn
  task automatic send_candidate(cand_t c);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_center_x <= c.cx; in_center_y <= c.cy;
    in_box_w <= c.w; in_box_h <= c.h;
    in_objectness <= c.obj; in_violated_score <= c.vs;
    in_fine_score <= c.fs; in_final_item <= c.fin;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_detections(c);
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned val);
    start <= 1'b0;
    while (det_q.size() != 0) @(posedge clk);
    repeat (4 * 32 * 32 + 200) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= 9'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IOU_THR:  thr_r = val & 9'h1FF;
      CFG_MIN_SIZE: minsz_r = val & 8'hFF;
      default:      keep_r = val & 6'h3F;
    endcase
  endtask

  function automatic cand_t rand_cand(bit fin, int unsigned wlo);
    cand_t c;
    c.cx = 8'($urandom); c.cy = 8'($urandom);
    c.w = 8'($urandom_range(wlo, 255)); c.h = 8'($urandom_range(wlo, 255));
    if ($urandom_range(0, 3) == 0) begin
      c.w = 8'($urandom); c.h = 8'($urandom);
    end
    c.obj = 8'($urandom); c.vs = 8'($urandom); c.fs = 8'($urandom);
    c.fin = fin;
    return c;
  endfunction

  row_t dir_tab[] = '{
    // lone final with full scores: edges clamp at zero, sizes at full scale
    '{'{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1}, 1'b1,
      '{1, 14'd0, 14'd0, 14'd8192, 14'd8192, 1, 8'd255, 1, 1}},
    // final below min_size: not-found
    '{'{8'd9, 8'd9, 8'd1, 8'd1, 8'd255, 8'd0, 8'd255, 1'b1}, 1'b1,
      '{0, 0, 0, 0, 0, 0, 0, 0, 1}},
    '{'{8'd255, 8'd255, 8'd2, 8'd2, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '{default: 0}},
    '{'{8'd100, 8'd100, 8'd40, 8'd40, 8'd200, 8'd10, 8'd250, 1'b0}, 1'b0, '{default: 0}},
    '{'{8'd102, 8'd101, 8'd40, 8'd41, 8'd200, 8'd250, 8'd10, 1'b0}, 1'b0, '{default: 0}},
    '{'{8'd30, 8'd200, 8'd60, 8'd10, 8'd128, 8'd77, 8'd77, 1'b0}, 1'b0, '{default: 0}},
    '{'{8'd30, 8'd200, 8'd60, 8'd10, 8'd128, 8'd77, 8'd77, 1'b0}, 1'b0, '{default: 0}},
    '{'{8'd170, 8'd85, 8'd255, 8'd3, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '{default: 0}},
    '{'{8'd1, 8'd254, 8'd128, 8'd127, 8'd1, 8'd255, 8'd254, 1'b1}, 1'b0, '{default: 0}}
  };

  initial begin
    cand_t c;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].chk) begin
        send_candidate(dir_tab[i].c);
        void'(det_q.pop_back());
        det_q.insert(det_q.size(), dir_tab[i].d);
      end else begin
        send_candidate(dir_tab[i].c);
      end
    end
    // zero-area boxes, ties, tiny capacity, extreme thresholds
    write_reg(CFG_MIN_SIZE, 0);
    write_reg(CFG_IOU_THR, 0);
    send_candidate('{8'd5, 8'd5, 8'd0, 8'd0, 8'd9, 8'd9, 8'd9, 1'b0});
    send_candidate('{8'd5, 8'd5, 8'd0, 8'd4, 8'd9, 8'd9, 8'd9, 1'b0});
    send_candidate('{8'd5, 8'd5, 8'd3, 8'd4, 8'd9, 8'd9, 8'd9, 1'b1});
    write_reg(CFG_KEEP_CNT, 0);
    send_candidate('{8'd50, 8'd50, 8'd8, 8'd8, 8'd90, 8'd9, 8'd9, 1'b0});
    send_candidate('{8'd90, 8'd90, 8'd8, 8'd8, 8'd90, 8'd99, 8'd9, 1'b1});
    write_reg(CFG_KEEP_CNT, 63);
    write_reg(CFG_IOU_THR, 511);
    for (int i = 0; i < 5; i++) send_candidate(rand_cand(i == 4, 0));
    write_reg(CFG_IOU_THR, 256);
    for (int i = 0; i < 5; i++) send_candidate(rand_cand(i == 4, 0));

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_IOU_THR, (ph == 0) ? 154 : $urandom_range(0, 300));
      write_reg(CFG_MIN_SIZE, (ph == 7) ? 255 : $urandom_range(0, 20));
      write_reg(CFG_KEEP_CNT, (ph == 1) ? 1 : (ph == 2) ? 32 : $urandom_range(0, 40));
      for (int f = 0; f < 4; f++) begin
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          c = rand_cand(i == n - 1, minsz_r);
          if ($urandom_range(0, 9) == 0) c.fin = 1'($urandom);
          send_candidate(c);
        end
        // cut capacity mid-frame once, in phase 5 after the second frame
        if (ph == 5 && f == 1) begin
          write_reg(CFG_KEEP_CNT, 3);
          for (int i = 0; i < 6; i++) send_candidate(rand_cand(0, 0));
          write_reg(CFG_KEEP_CNT, 2);
          send_candidate(rand_cand(1, 0));
        end
      end
    end
    send_candidate(rand_cand(1, 0));
    start <= 1'b0;
    while (det_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
